FILE: rtl/core/kwct_pkg.sv
// kwct_pkg: codes, types and fixed widths shared by the coalescing table
// files; no dependencies
package kwct_pkg;

  // fixed field widths of the transaction ports
  localparam int PORT_W   = 32;
  localparam int SERIAL_W = 32;
  localparam int DELTA_W  = 32;
  localparam int SUM_W    = 64;
  localparam int KIND_W   = 3;
  localparam int FUNC_W   = 3;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [FUNC_W-1:0] func_t;

  // pending write kinds, also used on the result port
  localparam kind_t K_TRUNC  = 3'd0;
  localparam kind_t K_INSERT = 3'd1;
  localparam kind_t K_UPDATE = 3'd2;
  localparam kind_t K_MOVE   = 3'd3;
  localparam kind_t K_DELETE = 3'd4;
  localparam kind_t K_ACK    = 3'd5;

  // operation codes
  localparam func_t FN_INSERT   = 3'd0;
  localparam func_t FN_UPDATE   = 3'd1;
  localparam func_t FN_DELETE   = 3'd2;
  localparam func_t FN_TRUNCATE = 3'd3;
  localparam func_t FN_DRAIN    = 3'd4;

endpackage

FILE: rtl/core/kwct_store.sv
// kwct_store: entry table of the coalescing unit, valid flops plus
// single-read registered memory for key, kind, serial and value; uses kwct_pkg
module kwct_store #(
  parameter int DEPTH = 16,
  parameter int KEY_W = 32,
  parameter int VAL_W = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(DEPTH)-1:0]        rd_idx,
  output logic                            rd_valid,
  output logic [KEY_W-1:0]                rd_key,
  output kwct_pkg::kind_t                 rd_kind,
  output logic [kwct_pkg::SERIAL_W-1:0]   rd_serial,
  output logic [VAL_W-1:0]                rd_value,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_idx,
  input  logic [KEY_W-1:0]                wr_key,
  input  kwct_pkg::kind_t                 wr_kind,
  input  logic [kwct_pkg::SERIAL_W-1:0]   wr_serial,
  input  logic [VAL_W-1:0]                wr_value,
  input  logic                            inv_en,
  input  logic [$clog2(DEPTH)-1:0]        inv_idx,
  input  logic                            clr_all
);
  import kwct_pkg::*;

  logic [DEPTH-1:0]    valid_r;
  logic [KEY_W-1:0]    key_mem    [DEPTH];
  kind_t               kind_mem   [DEPTH];
  logic [SERIAL_W-1:0] serial_mem [DEPTH];
  logic [VAL_W-1:0]    value_mem  [DEPTH];

  // valid bits: set by a write, cleared at reset, by invalidate and by truncate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr_all) begin
      valid_r <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (inv_en) begin
        valid_r[inv_idx] <= 1'b0;
      end
    end
  end

  // entry write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx]    <= wr_key;
      kind_mem[wr_idx]   <= wr_kind;
      serial_mem[wr_idx] <= wr_serial;
      value_mem[wr_idx]  <= wr_value;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_valid  <= valid_r[rd_idx];
    rd_key    <= key_mem[rd_idx];
    rd_kind   <= kind_mem[rd_idx];
    rd_serial <= serial_mem[rd_idx];
    rd_value  <= value_mem[rd_idx];
  end

`ifndef SYNTHESIS
  // write and invalidate are never issued together
  a_no_wr_inv: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && inv_en))
    else $error("kwct_store: write and invalidate in the same cycle");

  // a written entry is marked valid on the next cycle at that index
  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !clr_all |=> valid_r[$past(wr_idx)])
    else $error("kwct_store: written entry not valid");

  // truncate leaves no entry valid
  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr_all |=> (valid_r == '0))
    else $error("kwct_store: entries survive a clear");
`endif

endmodule

FILE: rtl/core/keyed_write_coalescing_table_unit.sv
// keyed_write_coalescing_table_unit: top level of the write coalescing table,
// sequencer with one shared scan comparator; uses kwct_pkg and kwct_store
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high and
//   busy low (in_func, in_key_id, in_value_handle, in_size_delta).
//   Result channel: each result is on the out_ ports for exactly one cycle,
//   marked by out_valid; out_last marks the final result of a transaction.
//   Insert, update and delete walk the table one entry per cycle through the
//   single read port of the entry store, looking for the key and a free
//   entry, then do one read-modify-write: busy drops in the same cycle as
//   the ack shows, so a new transaction can be taken while the ack is on
//   the ports.
//   Truncate and unused codes need no scan and go straight to the ack step.
//   Drain runs a selection pass over the table for each result with the same
//   comparator (next larger serial, truncate first, then lower index on a
//   tie): up to TABLE_DEPTH + 1 results, busy held until the last one. An
//   empty drain gives one result.
//   Reset (rst_n low, synchronous) empties the table, drops any pending
//   truncate and zeroes the serial counter and the running delta total.
//   The receiver cannot stall; results are never held back.
module keyed_write_coalescing_table_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  kwct_pkg::func_t                     in_func,
  input  logic [kwct_pkg::PORT_W-1:0]         in_key_id,
  input  logic [kwct_pkg::PORT_W-1:0]         in_value_handle,
  input  logic signed [kwct_pkg::DELTA_W-1:0] in_size_delta,
  output logic                                out_valid,
  output kwct_pkg::kind_t                     out_write_kind,
  output logic [kwct_pkg::PORT_W-1:0]         out_key,
  output logic [kwct_pkg::PORT_W-1:0]         out_value,
  output logic [kwct_pkg::SERIAL_W-1:0]       out_serial,
  output logic signed [kwct_pkg::SUM_W-1:0]   out_total_delta,
  output logic                                out_last,
  output logic                                out_table_full
);
  import kwct_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] SCAN_END = CW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DSCAN,
    S_DEMIT
  } state_t;

  state_t state_r;

  // latched transaction
  func_t                     func_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [VALUE_BITS-1:0]     value_r;
  logic signed [DELTA_W-1:0] delta_r;

  // persistent state
  logic                      trunc_pending_r;
  logic [SERIAL_W-1:0]       trunc_serial_r;
  logic [SERIAL_W-1:0]       ser_cnt_r;
  logic signed [SUM_W-1:0]   delta_sum_r;

  // scan pipeline
  logic [CW-1:0]             scan_idx_r;
  logic                      chk_r;
  logic [IW-1:0]             chk_idx_r;

  // mutation lookup results
  logic                      hit_r;
  logic [IW-1:0]             hit_idx_r;
  kind_t                     hit_kind_r;
  logic                      free_found_r;
  logic [IW-1:0]             free_idx_r;

  // drain selection
  logic                      first_r;
  logic                      found_r;
  logic                      many_r;
  logic [SERIAL_W-1:0]       low_s_r;
  logic [CW-1:0]             low_rank_r;
  logic [SERIAL_W-1:0]       best_s_r;
  logic [CW-1:0]             best_rank_r;
  kind_t                     best_kind_r;
  logic [KEY_BITS-1:0]       best_key_r;
  logic [VALUE_BITS-1:0]     best_val_r;

  // registered result
  logic                      out_valid_r;
  kind_t                     out_kind_r;
  logic [PORT_W-1:0]         out_key_r;
  logic [PORT_W-1:0]         out_value_r;
  logic [SERIAL_W-1:0]       out_serial_r;
  logic signed [SUM_W-1:0]   out_total_r;
  logic                      out_last_r;
  logic                      out_full_r;

  // store read data
  logic                      rd_valid;
  logic [KEY_BITS-1:0]       rd_key;
  kind_t                     rd_kind;
  logic [SERIAL_W-1:0]       rd_serial;
  logic [VALUE_BITS-1:0]     rd_value;
  logic [IW-1:0]             rd_idx;

  // apply step
  logic                      ap_write;
  logic                      ap_inv;
  logic                      ap_clr;
  logic [IW-1:0]             ap_idx;
  kind_t                     ap_kind;
  kind_t                     old_kind;
  logic [VALUE_BITS-1:0]     ap_value;
  logic [SERIAL_W-1:0]       ap_serial;
  logic                      ap_full;
  logic [SERIAL_W-1:0]       new_serial;
  logic [SERIAL_W-1:0]       ser_cnt_nxt;
  logic                      trunc_pending_nxt;
  logic [SERIAL_W-1:0]       trunc_serial_nxt;
  logic signed [SUM_W-1:0]   delta_sum_nxt;
  logic signed [SUM_W-1:0]   delta_ext;

  // shared scan comparator
  logic                      key_match;
  logic [CW-1:0]             cand_rank;
  logic                      cand_above;
  logic                      cand_better;
  logic                      scan_done;
  logic                      trunc_next_ok;

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_write_kind  = out_kind_r;
  assign out_key         = out_key_r;
  assign out_value       = out_value_r;
  assign out_serial      = out_serial_r;
  assign out_total_delta = out_total_r;
  assign out_last        = out_last_r;
  assign out_table_full  = out_full_r;

  // read address follows the scan counter
  assign rd_idx    = (scan_idx_r < SCAN_END) ? scan_idx_r[IW-1:0] : '0;
  assign scan_done = chk_r && (chk_idx_r == LAST_IDX);

  // key compare for lookups, serial/rank compare for drain ordering
  assign key_match   = rd_valid && (rd_key == key_r);
  assign cand_rank   = CW'(chk_idx_r) + CW'(1);
  assign cand_above  = first_r || (rd_serial > low_s_r) ||
                       ((rd_serial == low_s_r) && (cand_rank > low_rank_r));
  assign cand_better = !found_r || (rd_serial < best_s_r);
  // pending truncate stays a candidate of the next pass only above the bound
  assign trunc_next_ok = trunc_pending_r && (trunc_serial_r > best_s_r);

  assign delta_ext  = {{(SUM_W - DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
  assign new_serial = ser_cnt_r + SERIAL_W'(1);
  assign old_kind   = hit_r ? hit_kind_r : K_ACK;

  // merge rules of one mutation
  always_comb begin
    ap_write          = 1'b0;
    ap_inv            = 1'b0;
    ap_clr            = 1'b0;
    ap_idx            = hit_r ? hit_idx_r : free_idx_r;
    ap_kind           = K_DELETE;
    ap_serial         = '0;
    ap_full           = 1'b0;
    ser_cnt_nxt       = ser_cnt_r;
    trunc_pending_nxt = trunc_pending_r;
    trunc_serial_nxt  = trunc_serial_r;
    delta_sum_nxt     = delta_sum_r;
    case (func_r)
      FN_INSERT: begin
        ap_kind = (old_kind == K_DELETE) ? K_MOVE : K_INSERT;
      end
      FN_UPDATE: begin
        ap_kind = (old_kind == K_INSERT) ? K_INSERT : K_UPDATE;
      end
      default: begin
        ap_kind = K_DELETE;
      end
    endcase
    case (func_r)
      FN_INSERT, FN_UPDATE, FN_DELETE: begin
        delta_sum_nxt = delta_sum_r + delta_ext;
        if (func_r == FN_DELETE && hit_r && hit_kind_r == K_INSERT) begin
          ap_inv = 1'b1;
        end else if (!hit_r && !free_found_r) begin
          ap_full = 1'b1;
        end else begin
          ap_write    = 1'b1;
          ap_serial   = new_serial;
          ser_cnt_nxt = new_serial;
        end
      end
      FN_TRUNCATE: begin
        ap_clr        = 1'b1;
        delta_sum_nxt = delta_sum_r + delta_ext;
        if (!trunc_pending_r) begin
          trunc_pending_nxt = 1'b1;
          trunc_serial_nxt  = new_serial;
          ser_cnt_nxt       = new_serial;
          ap_serial         = new_serial;
        end else begin
          ap_serial = trunc_serial_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign ap_value = (ap_kind == K_DELETE) ? '0 : value_r;

  // entry store
  kwct_store #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (KEY_BITS),
    .VAL_W (VALUE_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (rd_idx),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key),
    .rd_kind   (rd_kind),
    .rd_serial (rd_serial),
    .rd_value  (rd_value),
    .wr_en     (ap_write && (state_r == S_APPLY)),
    .wr_idx    (ap_idx),
    .wr_key    (key_r),
    .wr_kind   (ap_kind),
    .wr_serial (ap_serial),
    .wr_value  (ap_value),
    .inv_en    (ap_inv && (state_r == S_APPLY)),
    .inv_idx   (hit_idx_r),
    .clr_all   (ap_clr && (state_r == S_APPLY))
  );

  // sequencer, persistent state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      trunc_pending_r <= 1'b0;
      trunc_serial_r  <= '0;
      ser_cnt_r       <= '0;
      delta_sum_r     <= '0;
      chk_r           <= 1'b0;
      scan_idx_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r       <= in_func;
            key_r        <= KEY_BITS'(in_key_id);
            value_r      <= VALUE_BITS'(in_value_handle);
            delta_r      <= in_size_delta;
            scan_idx_r   <= '0;
            chk_r        <= 1'b0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            // drain pass starts with the pending truncate as candidate
            first_r      <= 1'b1;
            found_r      <= trunc_pending_r;
            many_r       <= 1'b0;
            best_s_r     <= trunc_serial_r;
            best_rank_r  <= '0;
            best_kind_r  <= K_TRUNC;
            best_key_r   <= '0;
            best_val_r   <= '0;
            if (in_func inside {FN_INSERT, FN_UPDATE, FN_DELETE}) begin
              state_r <= S_SCAN;
            end else if (in_func == FN_DRAIN) begin
              state_r <= S_DSCAN;
            end else begin
              state_r <= S_APPLY;
            end
          end
        end

        // key lookup and first free entry
        S_SCAN: begin
          if (scan_idx_r != SCAN_END) begin
            chk_r      <= 1'b1;
            chk_idx_r  <= scan_idx_r[IW-1:0];
            scan_idx_r <= scan_idx_r + CW'(1);
          end else begin
            chk_r <= 1'b0;
          end
          if (chk_r) begin
            if (key_match && !hit_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= chk_idx_r;
              hit_kind_r <= rd_kind;
            end
            if (!rd_valid && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= chk_idx_r;
            end
          end
          if (scan_done) begin
            state_r <= S_APPLY;
          end
        end

        // read-modify-write and ack
        S_APPLY: begin
          trunc_pending_r <= trunc_pending_nxt;
          trunc_serial_r  <= trunc_serial_nxt;
          ser_cnt_r       <= ser_cnt_nxt;
          delta_sum_r     <= delta_sum_nxt;
          out_valid_r     <= 1'b1;
          out_kind_r      <= K_ACK;
          out_key_r       <= PORT_W'(key_r);
          out_value_r     <= '0;
          out_serial_r    <= ap_serial;
          out_total_r     <= delta_sum_nxt;
          out_last_r      <= 1'b1;
          out_full_r      <= ap_full;
          state_r         <= S_IDLE;
        end

        // one selection pass: smallest (serial, rank) above the last emitted
        S_DSCAN: begin
          if (scan_idx_r != SCAN_END) begin
            chk_r      <= 1'b1;
            chk_idx_r  <= scan_idx_r[IW-1:0];
            scan_idx_r <= scan_idx_r + CW'(1);
          end else begin
            chk_r <= 1'b0;
          end
          if (chk_r && rd_valid && cand_above) begin
            found_r <= 1'b1;
            if (found_r) begin
              many_r <= 1'b1;
            end
            if (cand_better) begin
              best_s_r    <= rd_serial;
              best_rank_r <= cand_rank;
              best_kind_r <= rd_kind;
              best_key_r  <= rd_key;
              best_val_r  <= (rd_kind == K_DELETE) ? '0 : rd_value;
            end
          end
          if (scan_done) begin
            state_r <= S_DEMIT;
          end
        end

        // emit the pass winner, or a bare ack if none, start the next pass if more remain
        S_DEMIT: begin
          out_valid_r  <= 1'b1;
          out_total_r  <= delta_sum_r;
          out_full_r   <= 1'b0;
          if (!found_r) begin
            out_kind_r   <= K_ACK;
            out_key_r    <= '0;
            out_value_r  <= '0;
            out_serial_r <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            out_kind_r   <= best_kind_r;
            out_key_r    <= PORT_W'(best_key_r);
            out_value_r  <= PORT_W'(best_val_r);
            out_serial_r <= best_s_r;
            out_last_r   <= !many_r;
            if (many_r) begin
              low_s_r     <= best_s_r;
              low_rank_r  <= best_rank_r;
              first_r     <= 1'b0;
              found_r     <= trunc_next_ok;
              many_r      <= 1'b0;
              best_s_r    <= trunc_serial_r;
              best_rank_r <= '0;
              best_kind_r <= K_TRUNC;
              best_key_r  <= '0;
              best_val_r  <= '0;
              scan_idx_r  <= '0;
              chk_r       <= 1'b0;
              state_r     <= S_DSCAN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // results come only out of the apply and emit steps
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_APPLY || state_r == S_DEMIT))
    else $error("kwct: result without apply or emit step");

  // an accepted transaction keeps the unit busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("kwct: transaction accepted but unit not busy");

  // a dropped write is flagged only on a final ack
  a_full_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_last && (out_write_kind == K_ACK))
    else $error("kwct: table full flag on a non-ack result");

  // the unit goes idle exactly with the final result of a transaction
  a_idle_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last)
    else $error("kwct: idle without a final result");
`endif

endmodule
